/* hw/rtl/wpf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the waypoint path follower.
// No dependencies.
package wpf_pkg;

  localparam int MAX_WAYPOINTS_DEF = 64;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [1:0] REG_SPEED = 2'd0;
  localparam logic [1:0] REG_MODE  = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;
  localparam logic [1:0] REG_MIND  = 2'd3;

  localparam logic [1:0] MODE_ONCE = 2'd0;
  localparam logic [1:0] MODE_LOOP = 2'd1;
  localparam logic [1:0] MODE_PING = 2'd2;
  localparam logic [1:0] MODE_ONCE_ALT = 2'd3;

  typedef struct packed {
    logic [30:0]        dwell;
    logic [15:0]        rw;
    logic [15:0]        rz;
    logic [15:0]        ry;
    logic [15:0]        rx;
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } entry_t;

endpackage

/* hw/rtl/waypoint_path_follower_core.sv */
`timescale 1ns / 1ps
// Waypoint path follower: entry memory, tick sequencer, APB register file.
// Depends on wpf_pkg.
//
// A request is taken when start is high and busy is low. Its pose appears with done
// for one cycle and cannot be held off. A load answers in the cycle after it is taken. So does a tick
// that finds the path empty, ended, paused or a single entry. A moving tick keeps busy
// high while it steps through these states in order:
//   - entry memory reads of both segment ends
//   - the squared deltas through one shared multiplier
//   - the bit-serial square root
//   - the length compare
//   - the bit-serial division of speed*dt by the segment length
//   - the progress update
//   - the interpolation of the seven pose components through one shared
//     multiplier
// Three kinds of tick finish sooner:
//   - a tick that skips a short segment finishes at the length compare
//   - a tick on a zero-length segment skips the division and finishes at the progress update
//   - a tick that reaches the end of its segment finishes at the progress update
// The pose appears with done in the cycle in which busy falls.
module waypoint_path_follower_core
  import wpf_pkg::*;
#(
  parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic [15:0]        dt,
  input  logic [5:0]         slot,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [15:0] rot_x,
  input  logic signed [15:0] rot_y,
  input  logic signed [15:0] rot_z,
  input  logic signed [15:0] rot_w,
  input  logic [30:0]        dwell,
  output logic               done,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [15:0] out_qx,
  output logic signed [15:0] out_qy,
  output logic signed [15:0] out_qz,
  output logic signed [15:0] out_qw,
  output logic               finished
);

  localparam int IDX_W = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int CNT_W = $clog2(MAX_WAYPOINTS + 1);
  localparam int CW    = (CNT_W > 7) ? CNT_W : 7;
  localparam int SW    = CW + 2;
  localparam logic [CW-1:0] MAXN = CW'(MAX_WAYPOINTS);
  localparam logic signed [SW-1:0] ONE_S = SW'(1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RDA  = 4'd1;
  localparam logic [3:0] ST_RDB  = 4'd2;
  localparam logic [3:0] ST_SQ   = 4'd3;
  localparam logic [3:0] ST_SQRT = 4'd4;
  localparam logic [3:0] ST_LEN  = 4'd5;
  localparam logic [3:0] ST_DIV  = 4'd6;
  localparam logic [3:0] ST_PROG = 4'd7;
  localparam logic [3:0] ST_LERP = 4'd8;

  logic [30:0] speed;
  logic [1:0]  loop_mode;
  logic [6:0]  waypoint_count;
  logic [30:0] min_distance;

  logic [3:0]  state;
  entry_t      mem [MAX_WAYPOINTS];
  entry_t      rd_data, ea, eb;
  logic [IDX_W-1:0] rd_addr, segment, b_idx, seg_sat, slot_idx;
  logic        heading, ended;
  logic [16:0] progress;
  logic signed [32:0] pause_left;
  logic [46:0] num, quo;
  logic [32:0] ad [3];
  logic [63:0] prod_sq, sum, rem_s, root, bitv, trial_s, sum_fin;
  logic [5:0]  cnt;
  logic [33:0] len, drem;
  logic [34:0] trial_d;
  logic signed [50:0] prod_l;

  logic [CW-1:0] n_eff, cnt_ext, slot_ext;
  logic        slot_ok, accept, sh;
  logic [30:0] v_sel;
  logic [16:0] inc, psat;
  logic [17:0] psum;
  logic signed [32:0] diff_sel, base_sel, dx, dy, dz;
  logic signed [50:0] lerp_res;
  logic signed [SW-1:0] after;
  logic        adv_end, adv_flip, do_adv;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] s, input logic h,
                                                 input logic [1:0] m, input logic [CW-1:0] n);
    logic signed [SW-1:0] sx, nx, nn;
    sx = $signed({2'b00, CW'(s)});
    nn = $signed({2'b00, n});
    nx = h ? sx - ONE_S : sx + ONE_S;
    if (m == MODE_LOOP) begin
      if (nx < 0) nx = nn - ONE_S;
      else if (nx >= nn) nx = '0;
    end else begin
      if (nx < 0) nx = '0;
      else if (nx > nn - ONE_S) nx = nn - ONE_S;
    end
    return nx[IDX_W-1:0];
  endfunction

  assign pready = 1'b1;
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign finished = ended;

  always_comb begin
    unique case (paddr[3:2])
      REG_SPEED: prdata = {1'b0, speed};
      REG_MODE:  prdata = {30'd0, loop_mode};
      REG_COUNT: prdata = {25'd0, waypoint_count};
      REG_MIND:  prdata = {1'b0, min_distance};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed          <= 31'd65536;
      loop_mode      <= MODE_ONCE;
      waypoint_count <= '0;
      min_distance   <= 31'd1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_SPEED: speed          <= pwdata[30:0];
        REG_MODE:  loop_mode      <= pwdata[1:0];
        REG_COUNT: waypoint_count <= pwdata[6:0];
        REG_MIND:  min_distance   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_ext  = CW'(waypoint_count);
    n_eff    = (cnt_ext > MAXN) ? MAXN : cnt_ext;
    slot_ext = CW'(slot);
    slot_ok  = slot_ext < MAXN;
    slot_idx = slot_ext[IDX_W-1:0];
    seg_sat  = (CW'(segment) >= n_eff) ? IDX_W'(n_eff - CW'(1)) : segment;
    rd_addr  = (state == ST_IDLE) ? seg_sat : b_idx;

    dx = $signed({rd_data.x[31], rd_data.x}) - $signed({ea.x[31], ea.x});
    dy = $signed({rd_data.y[31], rd_data.y}) - $signed({ea.y[31], ea.y});
    dz = $signed({rd_data.z[31], rd_data.z}) - $signed({ea.z[31], ea.z});

    sh = ad[0][32] | ad[0][31] | ad[1][32] | ad[1][31] | ad[2][32] | ad[2][31];
    case (cnt[1:0])
      2'd0:    v_sel = sh ? ad[0][32:2] : ad[0][30:0];
      2'd1:    v_sel = sh ? ad[1][32:2] : ad[1][30:0];
      default: v_sel = sh ? ad[2][32:2] : ad[2][30:0];
    endcase
    sum_fin = sum + prod_sq;

    bitv    = 64'd1 << (7'd62 - {cnt, 1'b0});
    trial_s = root + bitv;
    len     = sh ? {root[31:0], 2'b00} : {2'b00, root[31:0]};
    trial_d = {drem, quo[46]};

    if (len == '0) inc = ONE_Q16;
    else if (quo > 47'(ONE_Q16)) inc = ONE_Q16;
    else inc = quo[16:0];
    psum = {1'b0, progress} + {1'b0, inc};
    psat = (psum > 18'(ONE_Q16)) ? ONE_Q16 : psum[16:0];

    case (cnt[2:0])
      3'd0:    diff_sel = $signed({eb.x[31], eb.x}) - $signed({ea.x[31], ea.x});
      3'd1:    diff_sel = $signed({eb.y[31], eb.y}) - $signed({ea.y[31], ea.y});
      3'd2:    diff_sel = $signed({eb.z[31], eb.z}) - $signed({ea.z[31], ea.z});
      3'd3:    diff_sel = 33'($signed(eb.rx)) - 33'($signed(ea.rx));
      3'd4:    diff_sel = 33'($signed(eb.ry)) - 33'($signed(ea.ry));
      3'd5:    diff_sel = 33'($signed(eb.rz)) - 33'($signed(ea.rz));
      default: diff_sel = 33'($signed(eb.rw)) - 33'($signed(ea.rw));
    endcase
    case (cnt[2:0])
      3'd1:    base_sel = 33'(ea.x);
      3'd2:    base_sel = 33'(ea.y);
      3'd3:    base_sel = 33'(ea.z);
      3'd4:    base_sel = 33'($signed(ea.rx));
      3'd5:    base_sel = 33'($signed(ea.ry));
      3'd6:    base_sel = 33'($signed(ea.rz));
      default: base_sel = 33'($signed(ea.rw));
    endcase
    lerp_res = 51'(base_sel) + (prod_l >>> 16);

    after    = heading ? $signed({2'b00, CW'(b_idx)}) - ONE_S
                       : $signed({2'b00, CW'(b_idx)}) + ONE_S;
    adv_end  = (loop_mode == MODE_ONCE || loop_mode == MODE_ONCE_ALT) && (b_idx == segment);
    adv_flip = (loop_mode == MODE_PING) &&
               ((after < 0) || (after >= $signed({2'b00, n_eff})));
    do_adv   = ((state == ST_LEN) && (len < {3'b000, min_distance})) ||
               ((state == ST_PROG) && (psat == ONE_Q16));
  end

  always_ff @(posedge clk) begin
    if (accept && action && slot_ok) begin
      mem[slot_idx] <= '{dwell: dwell, rw: rot_w, rz: rot_z, ry: rot_y, rx: rot_x,
                         z: pos_z, y: pos_y, x: pos_x};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      segment    <= '0;
      heading    <= 1'b0;
      progress   <= '0;
      pause_left <= '0;
      ended      <= 1'b0;
      out_x      <= '0;
      out_y      <= '0;
      out_z      <= '0;
      out_qx     <= '0;
      out_qy     <= '0;
      out_qz     <= '0;
      out_qw     <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (action) begin
              done <= 1'b1;
              if (slot_ok && slot == 6'd0) begin
                out_x      <= pos_x;
                out_y      <= pos_y;
                out_z      <= pos_z;
                out_qx     <= rot_x;
                out_qy     <= rot_y;
                out_qz     <= rot_z;
                out_qw     <= rot_w;
                pause_left <= {2'b00, dwell};
                segment    <= '0;
                heading    <= 1'b0;
                progress   <= '0;
                ended      <= 1'b0;
              end
            end else if (n_eff == '0 || ended) begin
              done <= 1'b1;
            end else if (pause_left > 0) begin
              pause_left <= pause_left - $signed({17'd0, dt});
              done       <= 1'b1;
            end else if (n_eff == CW'(1)) begin
              done <= 1'b1;
            end else begin
              segment <= seg_sat;
              b_idx   <= next_idx(seg_sat, heading, loop_mode, n_eff);
              num     <= {16'd0, speed} * {31'd0, dt};
              state   <= ST_RDA;
            end
          end
        end
        ST_RDA: begin
          ea    <= rd_data;
          state <= ST_RDB;
        end
        ST_RDB: begin
          eb      <= rd_data;
          ad[0]   <= dx[32] ? 33'(-dx) : 33'(dx);
          ad[1]   <= dy[32] ? 33'(-dy) : 33'(dy);
          ad[2]   <= dz[32] ? 33'(-dz) : 33'(dz);
          sum     <= '0;
          prod_sq <= '0;
          cnt     <= '0;
          state   <= ST_SQ;
        end
        ST_SQ: begin
          prod_sq <= (cnt < 6'd3) ? {2'b00, {31'd0, v_sel} * {31'd0, v_sel}} : '0;
          sum     <= sum_fin;
          cnt     <= cnt + 6'd1;
          if (cnt == 6'd3) begin
            rem_s <= sum_fin;
            root  <= '0;
            cnt   <= '0;
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (rem_s >= trial_s) begin
            rem_s <= rem_s - trial_s;
            root  <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) state <= ST_LEN;
        end
        ST_LEN: begin
          if (do_adv) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else if (len == '0) begin
            state <= ST_PROG;
          end else begin
            drem  <= '0;
            quo   <= num;
            cnt   <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (trial_d >= {1'b0, len}) begin
            drem <= 34'(trial_d - {1'b0, len});
            quo  <= {quo[45:0], 1'b1};
          end else begin
            drem <= trial_d[33:0];
            quo  <= {quo[45:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd46) state <= ST_PROG;
        end
        ST_PROG: begin
          cnt <= '0;
          if (psat == ONE_Q16) begin
            if (adv_end) progress <= psat;
            out_x  <= eb.x;
            out_y  <= eb.y;
            out_z  <= eb.z;
            out_qx <= eb.rx;
            out_qy <= eb.ry;
            out_qz <= eb.rz;
            out_qw <= eb.rw;
            done   <= 1'b1;
            state  <= ST_IDLE;
          end else begin
            progress <= psat;
            state    <= ST_LERP;
          end
        end
        ST_LERP: begin
          prod_l <= 51'(diff_sel) * $signed({34'd0, progress});
          cnt    <= cnt + 6'd1;
          case (cnt[2:0])
            3'd1:    out_x  <= lerp_res[31:0];
            3'd2:    out_y  <= lerp_res[31:0];
            3'd3:    out_z  <= lerp_res[31:0];
            3'd4:    out_qx <= lerp_res[15:0];
            3'd5:    out_qy <= lerp_res[15:0];
            3'd6:    out_qz <= lerp_res[15:0];
            3'd7:    out_qw <= lerp_res[15:0];
            default: ;
          endcase
          if (cnt == 6'd7) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (do_adv) begin
        if (adv_end) begin
          ended <= 1'b1;
        end else begin
          if (adv_flip) heading <= ~heading;
          segment    <= b_idx;
          progress   <= '0;
          pause_left <= {2'b00, eb.dwell};
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_done_on_finish: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done) else $error("sequencer left busy without a result");
  a_progress_sat: assert property (@(posedge clk) disable iff (rst)
    progress <= ONE_Q16) else $error("progress above one");
  a_tick_answer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !action) |=> (busy || done)) else $error("tick request dropped");
`endif

endmodule
